FILE: rtl/rtdo_pkg.sv
// ----------------------------------------------------------------------------
// rtdo_pkg: shared types and constants
// Constants, skew table and interface structs for the record to disk offset
// unit.
// ----------------------------------------------------------------------------
package rtdo_pkg;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;

	// register indexes, taken from paddr[4:3]
	localparam logic [1:0] REG_MAP_LOW         = 2'd0;
	localparam logic [1:0] REG_MAP_HIGH        = 2'd1;
	localparam logic [1:0] REG_RESERVED_TRACKS = 2'd2;

	localparam logic [3:0] RESERVED_TRACKS_RST = 4'd2;

	localparam int SECTORS_PER_TRACK = 26;
	// floor(v/26) == (v*2521)>>16 for every 11-bit v
	localparam int RECIP_26    = 2521;
	localparam int RECIP_SHIFT = 16;

	typedef struct packed {
		logic [63:0] map_low;
		logic [63:0] map_high;
		logic [3:0]  reserved_tracks;
	} cfg_t;

	typedef struct packed {
		logic        found;
		logic [6:0]  track;
		logic [4:0]  sector;
		logic [18:0] byte_offset;
		logic        last_in_extent;
	} result_t;

	// skew of 6 over a 26-sector track, one based
	function automatic logic [4:0] skew(input logic [4:0] idx);
		logic [4:0] s;
		case (idx)
			5'd0:  s = 5'd1;
			5'd1:  s = 5'd7;
			5'd2:  s = 5'd13;
			5'd3:  s = 5'd19;
			5'd4:  s = 5'd25;
			5'd5:  s = 5'd5;
			5'd6:  s = 5'd11;
			5'd7:  s = 5'd17;
			5'd8:  s = 5'd23;
			5'd9:  s = 5'd3;
			5'd10: s = 5'd9;
			5'd11: s = 5'd15;
			5'd12: s = 5'd21;
			5'd13: s = 5'd2;
			5'd14: s = 5'd8;
			5'd15: s = 5'd14;
			5'd16: s = 5'd20;
			5'd17: s = 5'd26;
			5'd18: s = 5'd6;
			5'd19: s = 5'd12;
			5'd20: s = 5'd18;
			5'd21: s = 5'd24;
			5'd22: s = 5'd4;
			5'd23: s = 5'd10;
			5'd24: s = 5'd16;
			5'd25: s = 5'd22;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/rtdo_cfg.sv
// ----------------------------------------------------------------------------
// rtdo_cfg: configuration registers
// APB-style register file holding the allocation map and reserved tracks.
// ----------------------------------------------------------------------------
module rtdo_cfg import rtdo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [63:0] map_low_q;
	logic [63:0] map_high_q;
	logic [3:0]  reserved_tracks_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_low_q         <= '0;
			map_high_q        <= '0;
			reserved_tracks_q <= RESERVED_TRACKS_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAP_LOW:         map_low_q         <= pwdata;
				REG_MAP_HIGH:        map_high_q        <= pwdata;
				REG_RESERVED_TRACKS: reserved_tracks_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MAP_LOW:         prdata = map_low_q;
			REG_MAP_HIGH:        prdata = map_high_q;
			REG_RESERVED_TRACKS: prdata = {60'd0, reserved_tracks_q};
			default:             prdata = '0;
		endcase
	end

	assign cfg.map_low         = map_low_q;
	assign cfg.map_high        = map_high_q;
	assign cfg.reserved_tracks = reserved_tracks_q;

endmodule

FILE: rtl/rtdo_xlate.sv
// ----------------------------------------------------------------------------
// rtdo_xlate: record translation
// Allocation byte lookup, virtual sector split by 26, skew and offset.
// ----------------------------------------------------------------------------
module rtdo_xlate import rtdo_pkg::*; (
	input  cfg_t       cfg,
	input  logic [6:0] record_number,
	output result_t    res
);

	logic [3:0]  grp_idx;
	logic [63:0] word;
	logic [7:0]  grp;
	logic [10:0] vsec;
	logic [22:0] prod;
	logic [6:0]  quot;
	logic [10:0] base;
	logic [10:0] rem_full;
	logic [4:0]  rem;
	logic [4:0]  sec;
	logic [8:0]  rsv_secs;
	logic [11:0] lin_sec;

	assign grp_idx = record_number[6:3];
	assign word    = grp_idx[3] ? cfg.map_high : cfg.map_low;
	assign grp     = word[{grp_idx[2:0], 3'b000} +: 8];
	assign vsec    = {grp, record_number[2:0]};

	assign prod = 23'(vsec) * 23'(RECIP_26);
	assign quot = prod[RECIP_SHIFT +: 7];

	// quot*26 by shifts
	assign base     = {quot, 4'b0} + {1'b0, quot, 3'b0} + {3'b0, quot, 1'b0};
	assign rem_full = vsec - base;
	assign rem      = rem_full[4:0];
	assign sec      = skew(rem);

	assign rsv_secs = {1'b0, cfg.reserved_tracks, 4'b0}
		+ {2'b0, cfg.reserved_tracks, 3'b0}
		+ {4'b0, cfg.reserved_tracks, 1'b0};
	assign lin_sec  = 12'(base) + 12'(rsv_secs) + 12'(sec) - 12'd1;

	always_comb begin
		if (grp == 8'd0) begin
			res = '0;
		end else begin
			res.found          = 1'b1;
			res.track          = quot + 7'(cfg.reserved_tracks);
			res.sector         = sec;
			res.byte_offset    = {lin_sec, 7'b0};
			res.last_in_extent = (record_number == 7'd127);
		end
	end

endmodule

FILE: rtl/record_to_disk_offset_unit.sv
// ----------------------------------------------------------------------------
// record_to_disk_offset_unit: record number to floppy address
// Translates a record number within an extent into track, sector and image
// byte offset through the allocation map and the 26-sector skew table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries record_number; a transaction
//   completes on a clock edge with in_valid high and in_stall low.
//   Output channel out_valid/out_stall carries found, track, sector,
//   byte_offset and last_in_extent, one result per input transaction.
//   The record is captured in the input register, translated in one pass
//   of logic and captured in the result register. Throughput is one
//   transaction per cycle while the receiver does not stall; the path is
//   set by the multiply by the reciprocal of 26 that splits the virtual sector.
//   When the receiver stalls, the result holds, the input register fills,
//   and in_stall rises only once both stages are occupied.
//   The APB port (pready always high) holds map_low at 0x00, map_high at
//   0x08 and reserved_tracks at 0x10; write it only while the unit is idle.
//   Reset empties both stages and sets the map to 0, reserved tracks to 2.
// ----------------------------------------------------------------------------
module record_to_disk_offset_unit import rtdo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [6:0]         record_number,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [6:0]         track,
	output logic [4:0]         sector,
	output logic [18:0]        byte_offset,
	output logic               last_in_extent
);

	cfg_t       cfg;
	result_t    res;
	result_t    res_s2;
	logic       vld_s1;
	logic       vld_s2;
	logic [6:0] rec_s1;
	logic       load_s2;
	logic       load_s1;

	rtdo_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rtdo_xlate u_xlate (
		.cfg           (cfg),
		.record_number (rec_s1),
		.res           (res)
	);

	assign load_s2  = !vld_s2 || !out_stall;
	assign in_stall = vld_s1 && !load_s2;
	assign load_s1  = !vld_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (load_s1)
				vld_s1 <= in_valid;
			if (load_s2)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid)
			rec_s1 <= record_number;
		if (load_s2 && vld_s1)
			res_s2 <= res;
	end

	assign out_valid      = vld_s2;
	assign found          = res_s2.found;
	assign track          = res_s2.track;
	assign sector         = res_s2.sector;
	assign byte_offset    = res_s2.byte_offset;
	assign last_in_extent = res_s2.last_in_extent;

`ifndef NO_ASSERTIONS
	// end of file gives all-zero fields
	a_eof_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |->
		(track == 7'd0 && sector == 5'd0 && byte_offset == 19'd0 && !last_in_extent))
		else $error("eof result carries nonzero fields");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (sector >= 5'd1 && sector <= 5'd26))
		else $error("sector out of range");

	// offset must agree with track and sector
	a_offset_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |->
		(byte_offset == 19'(({12'd0, track} * 19'd26 + 19'(sector) - 19'd1) * 19'd128)))
		else $error("byte offset disagrees with track and sector");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && out_valid && out_stall))
		else $error("input stalled with room in the pipeline");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s1)
		else $error("accepted transaction lost");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: record to disk offset unit testbench
// Programs the allocation map and reserved tracks through the register port.
// Streams record numbers into the unit and predicts each track, sector and
// image offset. Checks every result transaction in order, with random
// idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import rtdo_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic [6:0]         record_number;
	logic               out_valid;
	logic               out_stall;
	logic               found;
	logic [6:0]         track;
	logic [4:0]         sector;
	logic [18:0]        byte_offset;
	logic               last_in_extent;

	// local copy of the register file
	logic [63:0] map_lo_q;
	logic [63:0] map_hi_q;
	logic [3:0]  rsv_q;

	result_t     pending_locs[$];
	result_t     seen_loc;
	result_t     want_loc;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_len;
	bit          tx_gaps;
	bit          rx_gaps;

	record_to_disk_offset_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.record_number  (record_number),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.track          (track),
		.sector         (sector),
		.byte_offset    (byte_offset),
		.last_in_extent (last_in_extent)
	);

	always #6 clk = ~clk;

	assign seen_loc = {found, track, sector, byte_offset, last_in_extent};

	// skew of 6: first half of the track on 1,7,13.., second half shifted by one
	function automatic logic [4:0] skewed_sector(input int unsigned slot);
		return 5'((slot * 6) % 26 + 1 + ((slot >= 13) ? 1 : 0));
	endfunction

	function automatic result_t locate_record(input logic [6:0] rec);
		logic [7:0]  grp;
		logic [10:0] vsec;
		int unsigned trk;
		result_t     loc;
		grp = rec[6] ? map_hi_q[rec[5:3]*8 +: 8] : map_lo_q[rec[5:3]*8 +: 8];
		loc = '0;
		if (grp != 8'd0) begin
			vsec = {grp, rec[2:0]};
			trk = vsec / 26 + rsv_q;
			loc.found = 1'b1;
			loc.track = 7'(trk);
			loc.sector = skewed_sector(vsec % 26);
			loc.byte_offset = 19'((trk * 26 + loc.sector - 1) * 128);
			loc.last_in_extent = (rec == 7'd127);
		end
		return loc;
	endfunction

	function automatic string loc_str(input result_t r);
		return $sformatf("found=%0d track=%0d sector=%0d offset=%0d last=%0d",
			r.found, r.track, r.sector, r.byte_offset, r.last_in_extent);
	endfunction

	function automatic logic [63:0] random_map();
		logic [63:0] m;
		for (int b = 0; b < 8; b++) begin
			case ($urandom_range(0, 5))
				0:       m[8*b +: 8] = 8'h00;
				1:       m[8*b +: 8] = 8'hFF;
				default: m[8*b +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return m;
	endfunction

	task automatic log_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("ERROR %0t: %s", $time, msg);
	endtask

	// one register transaction, setup then access; reads are checked
	task automatic reg_access(input logic [1:0] idx, input bit wr, input logic [63:0] wdata);
		logic [63:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 3'b000};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr) begin
			case (idx)
				REG_MAP_LOW:         map_lo_q = wdata;
				REG_MAP_HIGH:        map_hi_q = wdata;
				REG_RESERVED_TRACKS: rsv_q = wdata[3:0];
				default:             ;
			endcase
		end else begin
			case (idx)
				REG_MAP_LOW:  want = map_lo_q;
				REG_MAP_HIGH: want = map_hi_q;
				default:      want = {60'd0, rsv_q};
			endcase
			if (prdata !== want)
				log_failure($sformatf("reg %0d read %h, want %h", idx, prdata, want));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_registers();
		reg_access(REG_MAP_LOW, 1'b0, '0);
		reg_access(REG_MAP_HIGH, 1'b0, '0);
		reg_access(REG_RESERVED_TRACKS, 1'b0, '0);
	endtask

	// drain: all results back, then let the two-stage pipe settle
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_locs.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_layout(input logic [63:0] lo, input logic [63:0] hi, input logic [3:0] rsv);
		settle();
		reg_access(REG_MAP_LOW, 1'b1, lo);
		reg_access(REG_MAP_HIGH, 1'b1, hi);
		reg_access(REG_RESERVED_TRACKS, 1'b1, {60'd0, rsv});
	endtask

	task automatic send_record(input logic [6:0] rec);
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		record_number <= rec;
		do @(posedge clk); while (in_stall);
		pending_locs.push_back(locate_record(rec));
		@(negedge clk);
	endtask

	// empty map after reset: every record is end of file
	task automatic test_reset_state();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		check_registers();
		send_record(7'd0);
		send_record(7'd63);
		send_record(7'd64);
		send_record(7'd127);
	endtask

	task automatic test_directed_layouts();
		logic [6:0] picks[14] = '{7'd0, 7'd1, 7'd7, 7'd8, 7'd15, 7'd16, 7'd23,
			7'd63, 7'd64, 7'd80, 7'd120, 7'd125, 7'd126, 7'd127};
		// group 255 in the last byte with 15 reserved tracks reaches the top offset
		set_layout(64'hAA55_7F80_03FF_0001, 64'hFF0D_4002_FE00_2013, 4'hF);
		check_registers();
		foreach (picks[i]) send_record(picks[i]);
		// last record of an empty group is end of file, not end of extent
		set_layout(64'hFFFF_FFFF_FFFF_FF01, 64'h00FF_FFFF_FFFF_FFFF, 4'h0);
		check_registers();
		send_record(7'd127);
		send_record(7'd0);
		send_record(7'd5);
		send_record(7'd56);
	endtask

	task automatic test_random_layouts();
		logic [6:0] rec;
		logic [3:0] rsv;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		rec = 7'd0;
		for (int phase = 0; phase < 12; phase++) begin
			case (phase % 3)
				0:       rsv = 4'h0;
				1:       rsv = 4'hF;
				default: rsv = 4'($urandom_range(0, 15));
			endcase
			set_layout(random_map(), random_map(), rsv);
			for (int n = 0; n < 100; n++) begin
				// mostly sequential runs, as a file read walks an extent
				if ($urandom_range(0, 3) == 0) rec = 7'($urandom_range(0, 127));
				else rec = rec + 7'd1;
				send_record(rec);
			end
		end
	endtask

	task automatic test_input_backpressure();
		set_layout(random_map(), random_map(), 4'($urandom_range(0, 15)));
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		hold_len = 120;
		for (int n = 0; n < 40; n++) send_record(7'($urandom_range(0, 127)));
	endtask

	task automatic test_streaming();
		set_layout(random_map(), random_map(), 4'($urandom_range(0, 15)));
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		for (int n = 0; n < 200; n++) send_record(7'($urandom_range(0, 127)));
	endtask

	// receiver: random stall bursts, or a long counted hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
				out_stall <= 1'b0;
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_locs.size() == 0) begin
				log_failure($sformatf("unexpected result: %s", loc_str(seen_loc)));
			end else begin
				want_loc = pending_locs.pop_front();
				if (seen_loc.found !== want_loc.found || seen_loc.track !== want_loc.track ||
						seen_loc.sector !== want_loc.sector ||
						seen_loc.byte_offset !== want_loc.byte_offset ||
						seen_loc.last_in_extent !== want_loc.last_in_extent)
					log_failure($sformatf("got %s, want %s", loc_str(seen_loc),
						loc_str(want_loc)));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		record_number = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		hold_len = 0;
		map_lo_q = '0;
		map_hi_q = '0;
		rsv_q = RESERVED_TRACKS_RST;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_state();
		test_directed_layouts();
		test_random_layouts();
		test_input_backpressure();
		test_streaming();
		settle();
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/rtdo_pkg.sv
rtl/rtdo_cfg.sv
rtl/rtdo_xlate.sv
rtl/record_to_disk_offset_unit.sv
sim/tb_top.sv
